// ----- hdl/ehd_pkg.sv -----
// Extendible hash directory: shared constants, codes and types.
// No dependencies; imported by ehd_copy, the top level and the testbench.
`timescale 1ns / 1ps

package ehd_pkg;

	localparam int MAX_DEPTH = 10;
	localparam int SLOTS     = 1 << MAX_DEPTH;
	localparam int AW        = MAX_DEPTH;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int WORD_W    = 32;
	localparam int POS_W     = 10;
	localparam int MODE_W    = 2;
	localparam int DOUT_W    = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOOKUP   = 2'd0,
		MODE_SET      = 2'd1,
		MODE_ALLOCATE = 2'd2,
		MODE_DOUBLE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CP_IDLE,
		CP_COPY,
		CP_LAST
	} cp_state_t;

	// copy sequencer -> table port control
	typedef struct packed {
		logic          busy;
		logic          done;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
	} copy_ctl_t;

endpackage

// ----- hdl/ehd_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ehd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/ehd_copy.sv -----
// Copy sequencer for a directory double: walks the lower half of the table,
// one read per cycle, writing each word in the cycle after its read into the upper half.
// Depends on ehd_pkg.
`timescale 1ns / 1ps

module ehd_copy (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [ehd_pkg::DEPTH_W-1:0] depth,
	output ehd_pkg::copy_ctl_t          ctl
);
	import ehd_pkg::*;

	cp_state_t     state_q, state_nx;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] wr_idx_q;
	logic          wr_pend_q;
	logic [AW-1:0] half;
	logic          last_rd;

	assign half    = AW'(1) << depth;
	assign last_rd = (idx_q == (half - AW'(1)));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			CP_IDLE: if (go) state_nx = CP_COPY;
			CP_COPY: if (last_rd) state_nx = CP_LAST;
			CP_LAST: state_nx = CP_IDLE;
			default: state_nx = CP_IDLE;
		endcase
	end

	always_comb begin
		ctl.busy    = (state_q != CP_IDLE);
		ctl.done    = (state_q == CP_LAST);
		ctl.rd_en   = (state_q == CP_COPY);
		ctl.rd_addr = idx_q;
		ctl.wr_en   = wr_pend_q;
		ctl.wr_addr = half | wr_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CP_IDLE;
			idx_q     <= '0;
			wr_pend_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			wr_pend_q <= (state_q == CP_COPY);
			if (state_q == CP_COPY) begin
				idx_q <= idx_q + AW'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CP_COPY) begin
			wr_idx_q <= idx_q;
		end
	end

endmodule

// ----- hdl/extendible_hash_directory_top.sv -----
// Extendible hash directory, top level: command port, table RAM, depth and
// bucket counter registers, result register. Depends on ehd_pkg, ehd_ram, ehd_copy.
`timescale 1ns / 1ps

// Usage
//  Command channel: a word (mode, position, new_bucket) is taken at a rising
//  edge with start high and busy low. Every word gives one result word.
//  Result channel: bucket, depth and error are valid for the single cycle in
//  which done is high; the receiver cannot stall, so nothing is held back.
//  Results: lookup, set, allocate and a rejected double report in the cycle
//  after acceptance; one such word can be taken every cycle while busy is low.
//  The lookup result comes from the registered read port of the table RAM.
//  A double at depth d holds busy high while the copy sequencer streams the
//  2^d lower-half words into the upper half (one RAM read and one write per
//  cycle), then reports in the cycle after CP_LAST with the new depth.
//  Reset: depth and bucket counter clear at once; no RAM clearing pass is
//  run. Slots at 2^depth and above are unreadable until a double overwrites them,
//  so only slot 0 can expose stale data; a single flag makes it read as
//  zero until first written.
//  Set writes the RAM at the accept edge, so a lookup in the next cycle
//  already sees the new word.

module extendible_hash_directory_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ehd_pkg::MODE_W-1:0] mode,
	input  logic [ehd_pkg::POS_W-1:0]  position,
	input  logic [ehd_pkg::WORD_W-1:0] new_bucket,
	output logic                       done,
	output logic [ehd_pkg::WORD_W-1:0] bucket,
	output logic [ehd_pkg::DOUT_W-1:0] depth,
	output logic                       error
);
	import ehd_pkg::*;

	// architectural state
	logic [DEPTH_W-1:0] depth_q;
	logic [WORD_W-1:0]  count_q;
	logic               slot0_ok_q;   // slot 0 written since reset

	// result register
	logic               done_q;
	logic               from_ram_s1;  // bucket comes from the RAM read port
	logic               rd_zero_s1;   // read hit slot 0 before its first write
	logic [WORD_W-1:0]  bucket_s1;
	logic               error_s1;

	copy_ctl_t          cctl;

	logic               accept;
	logic               pos_bad;
	logic               dbl_bad;
	logic               do_lookup;
	logic               do_set;
	logic               do_alloc;
	logic               do_double;
	logic               req_err;

	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic [WORD_W-1:0]  ram_wr_data;
	logic               ram_rd_en;
	logic [AW-1:0]      ram_rd_addr;
	logic [WORD_W-1:0]  ram_rd_data;
	logic [WORD_W-1:0]  rd_word;

	assign busy    = cctl.busy;
	assign accept  = start && !busy;

	// position in range when position < 2^depth
	assign pos_bad = ((WORD_W'(position) >> depth_q) != '0);
	assign dbl_bad = (depth_q >= DEPTH_W'(MAX_DEPTH));

	assign do_lookup = accept && (mode == MODE_LOOKUP) && !pos_bad;
	assign do_set    = accept && (mode == MODE_SET) && !pos_bad;
	assign do_alloc  = accept && (mode == MODE_ALLOCATE);
	assign do_double = accept && (mode == MODE_DOUBLE) && !dbl_bad;
	assign req_err   = ((mode == MODE_LOOKUP) || (mode == MODE_SET)) ? pos_bad : dbl_bad;

	// stale slot 0 masked to its reset value
	assign rd_word = rd_zero_s1 ? '0 : ram_rd_data;

	// table port muxing: sequencer owns the RAM while busy
	always_comb begin
		if (cctl.busy) begin
			ram_rd_en   = cctl.rd_en;
			ram_rd_addr = cctl.rd_addr;
			ram_wr_en   = cctl.wr_en;
			ram_wr_addr = cctl.wr_addr;
			ram_wr_data = rd_word;
		end else begin
			ram_rd_en   = do_lookup;
			ram_rd_addr = AW'(position);
			ram_wr_en   = do_set;
			ram_wr_addr = AW'(position);
			ram_wr_data = new_bucket;
		end
	end

	ehd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	ehd_copy u_copy (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (do_double),
		.depth  (depth_q),
		.ctl    (cctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			count_q    <= '0;
			slot0_ok_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			// non-double words and rejected doubles report next cycle
			done_q <= (accept && !do_double) || cctl.done;
			if (do_alloc) begin
				count_q <= count_q + WORD_W'(1);
			end
			if (do_set && (position == '0)) begin
				slot0_ok_q <= 1'b1;
			end
			if (cctl.done) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_rd_en) begin
			rd_zero_s1 <= (ram_rd_addr == '0) && !slot0_ok_q;
		end
		if (accept) begin
			from_ram_s1 <= do_lookup;
			bucket_s1   <= do_alloc ? count_q : '0;
			error_s1    <= (mode != MODE_ALLOCATE) && req_err;
		end else if (cctl.done) begin
			from_ram_s1 <= 1'b0;
			bucket_s1   <= '0;
			error_s1    <= 1'b0;
		end
	end

	assign done   = done_q;
	assign bucket = from_ram_s1 ? rd_word : bucket_s1;
	assign depth  = DOUT_W'(depth_q);
	assign error  = error_s1;

	// ---------------------------------------------------------------- checks
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !do_double) |=> done)
		else $error("single-cycle command gave no result");

	a_copy_result: assert property (@(posedge clk) disable iff (!arst_n)
		cctl.done |=> (done && !error && !busy))
		else $error("double finished without a clean result");

	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result while copy in progress");

	a_depth_limit: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("depth beyond maximum");

endmodule

// ----- dv/tb_extendible_hash_directory_top.sv -----
// Self-checking testbench for extendible_hash_directory_top: directed and random command words,
// a clocked driver and result monitor, and a directory predictor checked in result order.
// Depends on ehd_pkg and the extendible_hash_directory_top RTL.
`timescale 1ns / 1ps

module tb_extendible_hash_directory_top;

	import ehd_pkg::*;

	// Timing and run shape
	localparam int CLK_HALF     = 4;       // 8 ns period
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_WORDS = 1050;
	localparam int IDLE_PCT     = 38;      // percent chance that a free sender idles, outside the burst window
	localparam int BURST_LO     = 400;     // no sender gaps for words in [BURST_LO, BURST_HI)
	localparam int BURST_HI     = 600;
	localparam int DRAIN_CYCLES = 4;       // covers the result register; margin on top
	// The limit covers the slowest run, ~1100 words with gaps plus ten copy walks
	// (one per depth d = 0..9), many times over.
	localparam int CYCLE_LIMIT  = 200000;

	// One command word as the driver presents it
	typedef struct {
		logic [MODE_W-1:0] op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] value;
	} cmd_word_t;

	// One expected result word
	typedef struct {
		logic [WORD_W-1:0] bucket;
		logic [DOUT_W-1:0] depth;
		logic              error;
	} dir_result_t;

	// DUT connections; every input has a known value from time zero
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic [MODE_W-1:0] mode       = '0;
	logic [POS_W-1:0]  position   = '0;
	logic [WORD_W-1:0] new_bucket = '0;
	logic              busy;
	logic              done;
	logic [WORD_W-1:0] bucket;
	logic [DOUT_W-1:0] depth;
	logic              error;

	// Stimulus and scoreboard storage
	cmd_word_t   pending_words[$];
	dir_result_t expected_results[$];
	int          words_sent  = 0;
	int          cycle_count = 0;
	bit          check_failed = 1'b0;
	int          gen_depth   = 0;      // depth the generator assumes, to aim positions

	// Directory shadow state: table, global depth and allocation counter
	logic [WORD_W-1:0] table_model [SLOTS];
	int                depth_model = 0;
	logic [WORD_W-1:0] alloc_count_model = '0;

	extendible_hash_directory_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.position   (position),
		.new_bucket (new_bucket),
		.done       (done),
		.bucket     (bucket),
		.depth      (depth),
		.error      (error)
	);

	always #CLK_HALF clk = ~clk;

	// Apply one accepted word to the shadow directory and queue its result.
	// Out-of-range lookup/set and double at max depth leave state alone and
	// report bucket 0 with error high. Allocate and double ignore position
	// and new_bucket. The counter wraps at 2^32 with no error.
	task automatic apply_directory_op(input logic [MODE_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] value);
		dir_result_t res;
		int          half;
		res.bucket = '0;
		res.error  = 1'b0;
		if (op == MODE_LOOKUP || op == MODE_SET) begin
			if (int'(pos) >= (1 << depth_model)) begin
				res.error = 1'b1;
			end else if (op == MODE_LOOKUP) begin
				res.bucket = table_model[pos];
			end else begin
				table_model[pos] = value;
			end
		end else if (op == MODE_ALLOCATE) begin
			res.bucket        = alloc_count_model;
			alloc_count_model = alloc_count_model + 1'b1;
		end else begin
			if (depth_model >= MAX_DEPTH) begin
				res.error = 1'b1;
			end else begin
				// new upper half is a copy of the lower half
				half = 1 << depth_model;
				for (int i = 0; i < half; i++)
					table_model[half + i] = table_model[i];
				depth_model++;
			end
		end
		res.depth = DOUT_W'(depth_model);
		expected_results.push_back(res);
	endtask

	// Queue a word for the driver; track the depth so positions can be aimed
	task automatic queue_word(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] value);
		cmd_word_t w;
		w.op    = op;
		w.pos   = pos;
		w.value = value;
		pending_words.push_back(w);
		if (op == MODE_DOUBLE && gen_depth < MAX_DEPTH)
			gen_depth++;
	endtask

	// Position mostly inside the live directory, sometimes just past its end,
	// sometimes anywhere in the 10-bit field.
	function automatic logic [POS_W-1:0] pick_position();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return POS_W'($urandom_range(0, (1 << gen_depth) - 1));
		if (sel == 7 && gen_depth < MAX_DEPTH)
			return POS_W'(1 << gen_depth);
		return POS_W'($urandom);
	endfunction

	function automatic logic [WORD_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return WORD_W'($urandom);
	endfunction

	// Driver: a word is taken at an edge with start high and busy low. The
	// held word stays on the port while busy (copy walk). start gets exactly
	// one nonblocking assignment per edge, so back-to-back words never glitch.
	always @(posedge clk) begin
		cmd_word_t w;
		logic      next_start;
		bit        holding;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			holding = start;
			if (start && !busy) begin
				apply_directory_op(mode, position, new_bucket);
				words_sent++;
				holding = 1'b0;
			end
			next_start = holding;
			if (!holding && pending_words.size() != 0 &&
					((words_sent >= BURST_LO && words_sent < BURST_HI) ||
					 $urandom_range(0, 99) >= IDLE_PCT)) begin
				w          = pending_words.pop_front();
				mode       <= w.op;
				position   <= w.pos;
				new_bucket <= w.value;
				next_start = 1'b1;
			end
			start <= next_start;
		end
	end

	// Monitor: done marks a one-cycle result word; compare against the oldest
	// expectation field by field.
	always @(posedge clk) begin
		dir_result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result word with nothing expected: bucket %h depth %0d error %b",
					$time, bucket, depth, error);
				check_failed = 1'b1;
			end else begin
				exp_res = expected_results.pop_front();
				if (bucket !== exp_res.bucket) begin
					$display("%0t: bucket expected %h actual %h",
						$time, exp_res.bucket, bucket);
					check_failed = 1'b1;
				end
				if (depth !== exp_res.depth) begin
					$display("%0t: depth expected %0d actual %0d",
						$time, exp_res.depth, depth);
					check_failed = 1'b1;
				end
				if (error !== exp_res.error) begin
					$display("%0t: error expected %b actual %b",
						$time, exp_res.error, error);
					check_failed = 1'b1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int sel;
		for (int i = 0; i < SLOTS; i++)
			table_model[i] = '0;

		// Directed: depth 0 edges. Slot 0 reads zero before any write;
		// position 1 and the top position are already outside the directory.
		queue_word(MODE_LOOKUP,   10'd0,     32'h0000_0000);
		queue_word(MODE_LOOKUP,   10'd1,     32'hFFFF_FFFF);
		queue_word(MODE_SET,      10'd1,     32'hA5A5_A5A5);
		queue_word(MODE_LOOKUP,   10'h3FF,   32'h0000_0000);
		queue_word(MODE_SET,      10'd0,     32'hFFFF_FFFF);
		queue_word(MODE_LOOKUP,   10'd0,     32'h0000_0000);
		// allocate ignores position and new_bucket
		queue_word(MODE_ALLOCATE, 10'h3FF,   32'hFFFF_FFFF);
		queue_word(MODE_ALLOCATE, 10'd0,     32'h0000_0000);
		// first double: slot 1 inherits slot 0; junk fields are ignored
		queue_word(MODE_DOUBLE,   10'h3FF,   32'hFFFF_FFFF);
		queue_word(MODE_LOOKUP,   10'd1,     32'h0000_0000);
		queue_word(MODE_LOOKUP,   10'd2,     32'h0000_0000);
		queue_word(MODE_SET,      10'd1,     32'h0000_0000);
		queue_word(MODE_LOOKUP,   10'd1,     32'h0000_0000);
		queue_word(MODE_LOOKUP,   10'd0,     32'h0000_0000);
		queue_word(MODE_DOUBLE,   10'd0,     32'h0000_0000);
		queue_word(MODE_LOOKUP,   10'd3,     32'h0000_0000);
		queue_word(MODE_SET,      10'd3,     32'h8000_0001);
		queue_word(MODE_LOOKUP,   10'd3,     32'h0000_0000);
		queue_word(MODE_SET,      10'd4,     32'h1234_5678);
		queue_word(MODE_ALLOCATE, 10'h155,   32'h5555_5555);

		// Random: mostly in-range lookups and sets, some allocates, rare
		// doubles so every depth gets traffic before the directory tops out.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				queue_word(MODE_LOOKUP, pick_position(), pick_value());
			else if (sel < 75)
				queue_word(MODE_SET, pick_position(), pick_value());
			else if (sel < 97)
				queue_word(MODE_ALLOCATE, POS_W'($urandom), pick_value());
			else
				queue_word(MODE_DOUBLE, POS_W'($urandom), pick_value());
		end

		// Make sure the max-depth rejection and the top slot are hit
		while (gen_depth < MAX_DEPTH)
			queue_word(MODE_DOUBLE, POS_W'($urandom), pick_value());
		queue_word(MODE_DOUBLE,   10'h3FF, 32'hFFFF_FFFF);
		queue_word(MODE_LOOKUP,   10'h3FF, 32'h0000_0000);
		queue_word(MODE_SET,      10'h3FF, 32'hFFFF_FFFF);
		queue_word(MODE_LOOKUP,   10'h3FF, 32'h0000_0000);

		// Single reset at the start
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every result back, then a few quiet cycles.
		// Sampled on the falling edge to stay clear of the clocked blocks.
		do
			@(negedge clk);
		while (pending_words.size() != 0 || start || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (!check_failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/ehd_pkg.sv
hdl/ehd_ram.sv
hdl/ehd_copy.sv
hdl/extendible_hash_directory_top.sv
dv/tb_extendible_hash_directory_top.sv
